/* rtl/bbs_pkg.sv */
// ----------------------------------------------------------------------------
// bbs_pkg: shared types and constants for the bouncing balls step unit
// Ball table size, field widths, register indexes, datapath operations and
// controller states used by the controller, datapath and config registers.
// ----------------------------------------------------------------------------
package bbs_pkg;

	// ball table size and derived index width
	localparam int NUM_BALLS = 4;
	localparam int IDX_W     = (NUM_BALLS > 2) ? $clog2(NUM_BALLS) : 1;

	// field widths
	localparam int POS_W     = 12;
	localparam int RAD_W     = 10;
	localparam int VEL_W     = 8;
	localparam int BOX_W     = 11;
	localparam int BIDX_W    = 2;
	localparam int CFG_IDX_W = 2;

	// working widths of the wall update
	localparam int BND_W     = 14;
	localparam int WRK_W     = 16;

	// squared distance datapath
	localparam int MAG_W     = 12;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int ACC_W     = SQ_W + 1;

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t LAST_IDX      = idx_t'(NUM_BALLS - 1);
	localparam idx_t NEXT_LAST_IDX = idx_t'(NUM_BALLS - 2);

	// request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_LEFT   = 2'd0,
		REG_BOX_TOP    = 2'd1,
		REG_BOX_RIGHT  = 2'd2,
		REG_BOX_BOTTOM = 2'd3
	} cfg_reg_t;

	localparam logic [BOX_W-1:0] BOX_LEFT_RST   = 11'd30;
	localparam logic [BOX_W-1:0] BOX_TOP_RST    = 11'd30;
	localparam logic [BOX_W-1:0] BOX_RIGHT_RST  = 11'd700;
	localparam logic [BOX_W-1:0] BOX_BOTTOM_RST = 11'd500;

	typedef struct packed {
		logic [BOX_W-1:0] left;
		logic [BOX_W-1:0] top;
		logic [BOX_W-1:0] right;
		logic [BOX_W-1:0] bottom;
	} box_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MOVE,
		OP_WALL_LO,
		OP_WALL_HI,
		OP_PAIR_A,
		OP_PAIR_B,
		OP_SQ_X,
		OP_SQ_Y,
		OP_SQ_R,
		OP_SWAP,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		idx_t   idx_a;
		idx_t   idx_b;
	} dp_cmd_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOVE,
		ST_WALL_LO,
		ST_WALL_HI,
		ST_PAIR_A,
		ST_PAIR_B,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQ_R,
		ST_SWAP,
		ST_EMIT,
		ST_WAIT
	} ctrl_state_t;

endpackage

/* rtl/bbs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bbs_cfg_regs: box wall registers
// Four 11-bit wall coordinates written through a valid/ready write channel.
// ----------------------------------------------------------------------------
module bbs_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bbs_pkg::BOX_W-1:0]       cfg_data,
	output bbs_pkg::box_t                   box
);

	bbs_pkg::box_t box_q;

	// writes are always accepted
	assign cfg_ready = 1'b1;
	assign box       = box_q;

	// register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q.left   <= bbs_pkg::BOX_LEFT_RST;
			box_q.top    <= bbs_pkg::BOX_TOP_RST;
			box_q.right  <= bbs_pkg::BOX_RIGHT_RST;
			box_q.bottom <= bbs_pkg::BOX_BOTTOM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (bbs_pkg::cfg_reg_t'(cfg_index))
				bbs_pkg::REG_BOX_LEFT: begin
					box_q.left <= cfg_data;
				end
				bbs_pkg::REG_BOX_TOP: begin
					box_q.top <= cfg_data;
				end
				bbs_pkg::REG_BOX_RIGHT: begin
					box_q.right <= cfg_data;
				end
				bbs_pkg::REG_BOX_BOTTOM: begin
					box_q.bottom <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/bbs_datapath.sv */
// ----------------------------------------------------------------------------
// bbs_datapath: ball table and arithmetic
// Holds the ball table in flops with one read mux, runs the move and wall
// mirror steps, the pair distance test on one shared squaring unit, the
// velocity swap, and the output payload register.
// ----------------------------------------------------------------------------
module bbs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bbs_pkg::dp_cmd_t                    cmd,
	input  bbs_pkg::box_t                       box,
	input  logic [bbs_pkg::BIDX_W-1:0]          ball_index,
	input  logic signed [bbs_pkg::POS_W-1:0]    pos_x,
	input  logic signed [bbs_pkg::POS_W-1:0]    pos_y,
	input  logic [bbs_pkg::RAD_W-1:0]           radius,
	input  logic signed [bbs_pkg::VEL_W-1:0]    vel_x,
	input  logic signed [bbs_pkg::VEL_W-1:0]    vel_y,
	output logic [bbs_pkg::BIDX_W-1:0]          out_index,
	output logic signed [bbs_pkg::POS_W-1:0]    out_x,
	output logic signed [bbs_pkg::POS_W-1:0]    out_y,
	output logic [bbs_pkg::RAD_W-1:0]           out_radius,
	output logic                                last_ball
);

	// velocity negation, -128 saturates to +127
	function automatic logic signed [bbs_pkg::VEL_W-1:0] neg_vel(
		input logic signed [bbs_pkg::VEL_W-1:0] v);
		logic signed [bbs_pkg::VEL_W-1:0] r;
		if (v == {1'b1, {(bbs_pkg::VEL_W-1){1'b0}}}) begin
			r = {1'b0, {(bbs_pkg::VEL_W-1){1'b1}}};
		end else begin
			r = -v;
		end
		return r;
	endfunction

	// clamp a working position into the stored range
	function automatic logic signed [bbs_pkg::POS_W-1:0] sat_pos(
		input logic signed [bbs_pkg::WRK_W-1:0] v);
		logic signed [bbs_pkg::POS_W-1:0] r;
		logic signed [bbs_pkg::POS_W-1:0] pmin;
		logic signed [bbs_pkg::POS_W-1:0] pmax;
		pmin = {1'b1, {(bbs_pkg::POS_W-1){1'b0}}};
		pmax = {1'b0, {(bbs_pkg::POS_W-1){1'b1}}};
		if (v < bbs_pkg::WRK_W'(pmin)) begin
			r = pmin;
		end else if (v > bbs_pkg::WRK_W'(pmax)) begin
			r = pmax;
		end else begin
			r = v[bbs_pkg::POS_W-1:0];
		end
		return r;
	endfunction

	// ball table
	logic signed [bbs_pkg::POS_W-1:0] bx_q  [bbs_pkg::NUM_BALLS];
	logic signed [bbs_pkg::POS_W-1:0] by_q  [bbs_pkg::NUM_BALLS];
	logic        [bbs_pkg::RAD_W-1:0] br_q  [bbs_pkg::NUM_BALLS];
	logic signed [bbs_pkg::VEL_W-1:0] bvx_q [bbs_pkg::NUM_BALLS];
	logic signed [bbs_pkg::VEL_W-1:0] bvy_q [bbs_pkg::NUM_BALLS];

	// read port
	logic signed [bbs_pkg::POS_W-1:0] rd_x;
	logic signed [bbs_pkg::POS_W-1:0] rd_y;
	logic        [bbs_pkg::RAD_W-1:0] rd_r;
	logic signed [bbs_pkg::VEL_W-1:0] rd_vx;
	logic signed [bbs_pkg::VEL_W-1:0] rd_vy;

	// move and wall working registers
	logic signed [bbs_pkg::WRK_W-1:0] wx_q;
	logic signed [bbs_pkg::WRK_W-1:0] wy_q;
	logic signed [bbs_pkg::VEL_W-1:0] wvx_q;
	logic signed [bbs_pkg::VEL_W-1:0] wvy_q;
	logic signed [bbs_pkg::BND_W-1:0] lox_q;
	logic signed [bbs_pkg::BND_W-1:0] hix_q;
	logic signed [bbs_pkg::BND_W-1:0] loy_q;
	logic signed [bbs_pkg::BND_W-1:0] hiy_q;

	// pair working registers
	logic signed [bbs_pkg::POS_W-1:0] a_x_q;
	logic signed [bbs_pkg::POS_W-1:0] a_y_q;
	logic        [bbs_pkg::RAD_W-1:0] a_r_q;
	logic signed [bbs_pkg::VEL_W-1:0] a_vx_q;
	logic signed [bbs_pkg::VEL_W-1:0] a_vy_q;
	logic signed [bbs_pkg::VEL_W-1:0] b_vx_q;
	logic signed [bbs_pkg::VEL_W-1:0] b_vy_q;
	logic        [bbs_pkg::MAG_W-1:0] dxm_q;
	logic        [bbs_pkg::MAG_W-1:0] dym_q;
	logic        [bbs_pkg::RAD_W:0]   rs_q;
	logic        [bbs_pkg::ACC_W-1:0] acc_q;
	logic                             hit_q;

	// output payload
	logic [bbs_pkg::BIDX_W-1:0]       out_index_q;
	logic signed [bbs_pkg::POS_W-1:0] out_x_q;
	logic signed [bbs_pkg::POS_W-1:0] out_y_q;
	logic [bbs_pkg::RAD_W-1:0]        out_radius_q;
	logic                             last_q;

	// combinational results
	logic signed [bbs_pkg::WRK_W-1:0] mv_x;
	logic signed [bbs_pkg::WRK_W-1:0] mv_y;
	logic signed [bbs_pkg::BND_W-1:0] mv_lox;
	logic signed [bbs_pkg::BND_W-1:0] mv_hix;
	logic signed [bbs_pkg::BND_W-1:0] mv_loy;
	logic signed [bbs_pkg::BND_W-1:0] mv_hiy;
	logic signed [bbs_pkg::WRK_W-1:0] lox_w;
	logic signed [bbs_pkg::WRK_W-1:0] hix_w;
	logic signed [bbs_pkg::WRK_W-1:0] loy_w;
	logic signed [bbs_pkg::WRK_W-1:0] hiy_w;
	logic                             lo_fire_x;
	logic                             lo_fire_y;
	logic                             hi_fire_x;
	logic                             hi_fire_y;
	logic signed [bbs_pkg::WRK_W-1:0] hi_x;
	logic signed [bbs_pkg::WRK_W-1:0] hi_y;
	logic signed [bbs_pkg::POS_W:0]   dx_full;
	logic signed [bbs_pkg::POS_W:0]   dy_full;
	logic        [bbs_pkg::MAG_W-1:0] dx_mag;
	logic        [bbs_pkg::MAG_W-1:0] dy_mag;
	logic        [bbs_pkg::RAD_W:0]   rs_sum;
	logic        [bbs_pkg::MAG_W-1:0] sq_in;
	logic        [bbs_pkg::SQ_W-1:0]  sq;
	logic                             load_ok;

	// single read mux on the table
	assign rd_x  = bx_q[cmd.idx_a];
	assign rd_y  = by_q[cmd.idx_a];
	assign rd_r  = br_q[cmd.idx_a];
	assign rd_vx = bvx_q[cmd.idx_a];
	assign rd_vy = bvy_q[cmd.idx_a];

	// loads beyond the table are dropped
	assign load_ok = (int'(ball_index) < bbs_pkg::NUM_BALLS);

	// move step and wall bounds
	assign mv_x   = bbs_pkg::WRK_W'(rd_x) + bbs_pkg::WRK_W'(rd_vx);
	assign mv_y   = bbs_pkg::WRK_W'(rd_y) + bbs_pkg::WRK_W'(rd_vy);
	assign mv_lox = $signed({3'b000, box.left})   + $signed({4'b0000, rd_r});
	assign mv_hix = $signed({3'b000, box.right})  - $signed({4'b0000, rd_r});
	assign mv_loy = $signed({3'b000, box.top})    + $signed({4'b0000, rd_r});
	assign mv_hiy = $signed({3'b000, box.bottom}) - $signed({4'b0000, rd_r});

	assign lox_w = bbs_pkg::WRK_W'(lox_q);
	assign hix_w = bbs_pkg::WRK_W'(hix_q);
	assign loy_w = bbs_pkg::WRK_W'(loy_q);
	assign hiy_w = bbs_pkg::WRK_W'(hiy_q);

	// left/top checks; mirror is 2*bound - pos
	assign lo_fire_x = (wx_q <= lox_w);
	assign lo_fire_y = (wy_q <= loy_w);

	// right/bottom checks
	assign hi_fire_x = (wx_q >= hix_w);
	assign hi_fire_y = (wy_q >= hiy_w);
	assign hi_x      = hi_fire_x ? (hix_w + hix_w - wx_q) : wx_q;
	assign hi_y      = hi_fire_y ? (hiy_w + hiy_w - wy_q) : wy_q;

	// pair distance magnitudes and radius sum
	assign dx_full = $signed({a_x_q[bbs_pkg::POS_W-1], a_x_q})
		- $signed({rd_x[bbs_pkg::POS_W-1], rd_x});
	assign dy_full = $signed({a_y_q[bbs_pkg::POS_W-1], a_y_q})
		- $signed({rd_y[bbs_pkg::POS_W-1], rd_y});
	assign dx_mag  = dx_full[bbs_pkg::POS_W] ? bbs_pkg::MAG_W'(-dx_full)
		: dx_full[bbs_pkg::MAG_W-1:0];
	assign dy_mag  = dy_full[bbs_pkg::POS_W] ? bbs_pkg::MAG_W'(-dy_full)
		: dy_full[bbs_pkg::MAG_W-1:0];
	assign rs_sum  = {1'b0, a_r_q} + {1'b0, rd_r};

	// shared squaring unit
	always_comb begin
		case (cmd.op)
			bbs_pkg::OP_SQ_X: begin
				sq_in = dxm_q;
			end
			bbs_pkg::OP_SQ_Y: begin
				sq_in = dym_q;
			end
			default: begin
				sq_in = bbs_pkg::MAG_W'(rs_q);
			end
		endcase
	end

	assign sq = bbs_pkg::SQ_W'(sq_in) * bbs_pkg::SQ_W'(sq_in);

	// ball table writes: load, wall write-back, velocity swap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < bbs_pkg::NUM_BALLS; k++) begin
				bx_q[k]  <= '0;
				by_q[k]  <= '0;
				br_q[k]  <= '0;
				bvx_q[k] <= '0;
				bvy_q[k] <= '0;
			end
		end else begin
			case (cmd.op)
				bbs_pkg::OP_LOAD: begin
					if (load_ok) begin
						bx_q[bbs_pkg::idx_t'(ball_index)]  <= pos_x;
						by_q[bbs_pkg::idx_t'(ball_index)]  <= pos_y;
						br_q[bbs_pkg::idx_t'(ball_index)]  <= radius;
						bvx_q[bbs_pkg::idx_t'(ball_index)] <= vel_x;
						bvy_q[bbs_pkg::idx_t'(ball_index)] <= vel_y;
					end
				end
				bbs_pkg::OP_WALL_HI: begin
					bx_q[cmd.idx_a]  <= sat_pos(hi_x);
					by_q[cmd.idx_a]  <= sat_pos(hi_y);
					bvx_q[cmd.idx_a] <= hi_fire_x ? neg_vel(wvx_q) : wvx_q;
					bvy_q[cmd.idx_a] <= hi_fire_y ? neg_vel(wvy_q) : wvy_q;
				end
				bbs_pkg::OP_SWAP: begin
					if (hit_q) begin
						bvx_q[cmd.idx_a] <= b_vx_q;
						bvy_q[cmd.idx_a] <= b_vy_q;
						bvx_q[cmd.idx_b] <= a_vx_q;
						bvy_q[cmd.idx_b] <= a_vy_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working registers of the move, wall, pair and output steps
	always_ff @(posedge clk) begin
		case (cmd.op)
			bbs_pkg::OP_MOVE: begin
				wx_q  <= mv_x;
				wy_q  <= mv_y;
				wvx_q <= rd_vx;
				wvy_q <= rd_vy;
				lox_q <= mv_lox;
				hix_q <= mv_hix;
				loy_q <= mv_loy;
				hiy_q <= mv_hiy;
			end
			bbs_pkg::OP_WALL_LO: begin
				if (lo_fire_x) begin
					wx_q  <= lox_w + lox_w - wx_q;
					wvx_q <= neg_vel(wvx_q);
				end
				if (lo_fire_y) begin
					wy_q  <= loy_w + loy_w - wy_q;
					wvy_q <= neg_vel(wvy_q);
				end
			end
			bbs_pkg::OP_PAIR_A: begin
				a_x_q  <= rd_x;
				a_y_q  <= rd_y;
				a_r_q  <= rd_r;
				a_vx_q <= rd_vx;
				a_vy_q <= rd_vy;
			end
			bbs_pkg::OP_PAIR_B: begin
				b_vx_q <= rd_vx;
				b_vy_q <= rd_vy;
				dxm_q  <= dx_mag;
				dym_q  <= dy_mag;
				rs_q   <= rs_sum;
			end
			bbs_pkg::OP_SQ_X: begin
				acc_q <= bbs_pkg::ACC_W'(sq);
			end
			bbs_pkg::OP_SQ_Y: begin
				acc_q <= acc_q + bbs_pkg::ACC_W'(sq);
			end
			bbs_pkg::OP_SQ_R: begin
				hit_q <= (acc_q <= bbs_pkg::ACC_W'(sq));
			end
			bbs_pkg::OP_EMIT: begin
				out_index_q  <= bbs_pkg::BIDX_W'(cmd.idx_a);
				out_x_q      <= rd_x;
				out_y_q      <= rd_y;
				out_radius_q <= rd_r;
				last_q       <= (cmd.idx_a == bbs_pkg::LAST_IDX);
			end
			default: begin
			end
		endcase
	end

	assign out_index  = out_index_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_radius = out_radius_q;
	assign last_ball  = last_q;

endmodule

/* rtl/bbs_ctrl.sv */
// ----------------------------------------------------------------------------
// bbs_ctrl: tick sequencer
// State machine that walks the move/wall steps per ball, the pair tests in
// index order, and the result beats, one command per cycle outside ST_WAIT.
// ----------------------------------------------------------------------------
module bbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              req_type,
	output logic              in_stall,
	input  logic              out_stall,
	output logic              out_valid,
	output bbs_pkg::dp_cmd_t  cmd
);

	bbs_pkg::ctrl_state_t state_q;
	bbs_pkg::ctrl_state_t state_d;
	bbs_pkg::idx_t        i_q;
	bbs_pkg::idx_t        i_d;
	bbs_pkg::idx_t        j_q;
	bbs_pkg::idx_t        j_d;
	logic                 out_valid_q;

	// state, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bbs_pkg::ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			i_q         <= i_d;
			j_q         <= j_d;
			out_valid_q <= (state_d == bbs_pkg::ST_WAIT);
		end
	end

	// next state and counters
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		case (state_q)
			bbs_pkg::ST_IDLE: begin
				if (in_valid && (req_type == bbs_pkg::REQ_TICK)) begin
					state_d = bbs_pkg::ST_MOVE;
					i_d     = '0;
				end
			end
			bbs_pkg::ST_MOVE: begin
				state_d = bbs_pkg::ST_WALL_LO;
			end
			bbs_pkg::ST_WALL_LO: begin
				state_d = bbs_pkg::ST_WALL_HI;
			end
			bbs_pkg::ST_WALL_HI: begin
				if (i_q == bbs_pkg::LAST_IDX) begin
					state_d = bbs_pkg::ST_PAIR_A;
					i_d     = '0;
					j_d     = bbs_pkg::idx_t'(1);
				end else begin
					state_d = bbs_pkg::ST_MOVE;
					i_d     = i_q + bbs_pkg::idx_t'(1);
				end
			end
			bbs_pkg::ST_PAIR_A: begin
				state_d = bbs_pkg::ST_PAIR_B;
			end
			bbs_pkg::ST_PAIR_B: begin
				state_d = bbs_pkg::ST_SQ_X;
			end
			bbs_pkg::ST_SQ_X: begin
				state_d = bbs_pkg::ST_SQ_Y;
			end
			bbs_pkg::ST_SQ_Y: begin
				state_d = bbs_pkg::ST_SQ_R;
			end
			bbs_pkg::ST_SQ_R: begin
				state_d = bbs_pkg::ST_SWAP;
			end
			bbs_pkg::ST_SWAP: begin
				if (j_q != bbs_pkg::LAST_IDX) begin
					state_d = bbs_pkg::ST_PAIR_A;
					j_d     = j_q + bbs_pkg::idx_t'(1);
				end else if (i_q == bbs_pkg::NEXT_LAST_IDX) begin
					state_d = bbs_pkg::ST_EMIT;
					i_d     = '0;
				end else begin
					state_d = bbs_pkg::ST_PAIR_A;
					i_d     = i_q + bbs_pkg::idx_t'(1);
					j_d     = i_q + bbs_pkg::idx_t'(2);
				end
			end
			bbs_pkg::ST_EMIT: begin
				state_d = bbs_pkg::ST_WAIT;
			end
			bbs_pkg::ST_WAIT: begin
				if (!out_stall) begin
					if (i_q == bbs_pkg::LAST_IDX) begin
						state_d = bbs_pkg::ST_IDLE;
					end else begin
						state_d = bbs_pkg::ST_EMIT;
						i_d     = i_q + bbs_pkg::idx_t'(1);
					end
				end
			end
			default: begin
				state_d = bbs_pkg::ST_IDLE;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.op    = bbs_pkg::OP_NONE;
		cmd.idx_a = i_q;
		cmd.idx_b = j_q;
		case (state_q)
			bbs_pkg::ST_IDLE: begin
				if (in_valid && (req_type == bbs_pkg::REQ_LOAD)) begin
					cmd.op = bbs_pkg::OP_LOAD;
				end
			end
			bbs_pkg::ST_MOVE: begin
				cmd.op = bbs_pkg::OP_MOVE;
			end
			bbs_pkg::ST_WALL_LO: begin
				cmd.op = bbs_pkg::OP_WALL_LO;
			end
			bbs_pkg::ST_WALL_HI: begin
				cmd.op = bbs_pkg::OP_WALL_HI;
			end
			bbs_pkg::ST_PAIR_A: begin
				cmd.op = bbs_pkg::OP_PAIR_A;
			end
			bbs_pkg::ST_PAIR_B: begin
				cmd.op    = bbs_pkg::OP_PAIR_B;
				cmd.idx_a = j_q;
			end
			bbs_pkg::ST_SQ_X: begin
				cmd.op = bbs_pkg::OP_SQ_X;
			end
			bbs_pkg::ST_SQ_Y: begin
				cmd.op = bbs_pkg::OP_SQ_Y;
			end
			bbs_pkg::ST_SQ_R: begin
				cmd.op = bbs_pkg::OP_SQ_R;
			end
			bbs_pkg::ST_SWAP: begin
				cmd.op = bbs_pkg::OP_SWAP;
			end
			bbs_pkg::ST_EMIT: begin
				cmd.op = bbs_pkg::OP_EMIT;
			end
			default: begin
				cmd.op = bbs_pkg::OP_NONE;
			end
		endcase
	end

	// input is taken only between ticks
	assign in_stall  = (state_q != bbs_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* rtl/bouncing_balls_box_step_unit.sv */
// ----------------------------------------------------------------------------
// bouncing_balls_box_step_unit: ball table stepper for a walled box
// Input channel (in_valid/in_stall) takes load and tick requests; output
// channel (out_valid/out_stall) returns one beat per ball on each tick.
// Config channel (cfg_valid/cfg_ready) sets the four wall coordinates.
//
// A load beat is absorbed in its accept cycle and gives no result; the next
// request may follow in the next cycle.
// A tick runs the move, low-wall and high-wall steps for each ball, then
// for each pair i<j loads both balls and forms dx^2, dy^2 and rsum^2 in
// turn through one shared squaring unit before the velocity swap on a hit,
// then sends one result beat per ball. in_stall stays high for the whole
// tick. When out_stall is high the current beat holds and the sequencer
// waits.
// Reset clears the ball table to zero and loads the default walls
// (30, 30, 700, 500); cfg_ready is always high.
// ----------------------------------------------------------------------------
module bouncing_balls_box_step_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic [bbs_pkg::BIDX_W-1:0]        ball_index,
	input  logic signed [bbs_pkg::POS_W-1:0]  pos_x,
	input  logic signed [bbs_pkg::POS_W-1:0]  pos_y,
	input  logic [bbs_pkg::RAD_W-1:0]         radius,
	input  logic signed [bbs_pkg::VEL_W-1:0]  vel_x,
	input  logic signed [bbs_pkg::VEL_W-1:0]  vel_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bbs_pkg::BIDX_W-1:0]        out_index,
	output logic signed [bbs_pkg::POS_W-1:0]  out_x,
	output logic signed [bbs_pkg::POS_W-1:0]  out_y,
	output logic [bbs_pkg::RAD_W-1:0]         out_radius,
	output logic                              last_ball,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bbs_pkg::BOX_W-1:0]         cfg_data
);

	bbs_pkg::dp_cmd_t cmd;
	bbs_pkg::box_t    box;

	// wall registers
	bbs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.box       (box)
	);

	// sequencer
	bbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// ball table and arithmetic
	bbs_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.box        (box),
		.ball_index (ball_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.radius     (radius),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.out_index  (out_index),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_radius (out_radius),
		.last_ball  (last_ball)
	);

endmodule

/* rtl/bbs_checker.sv */
// ----------------------------------------------------------------------------
// bbs_checker: port-level checks for the ball stepper
// Watches the top-level channels for tick sequencing and result ordering.
// ----------------------------------------------------------------------------
module bbs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             req_type,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [bbs_pkg::BIDX_W-1:0]       out_index,
	input logic                             last_ball
);

	// an accepted tick keeps the input side busy
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (req_type == bbs_pkg::REQ_TICK) |=> in_stall)
		else $error("input taken right after a tick");

	// a load never blocks the next request
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (req_type == bbs_pkg::REQ_LOAD) |=> !in_stall)
		else $error("input stalled after a load");

	// result beats only appear inside a tick
	a_out_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result beat outside a tick");

	// the last beat of a tick closes the output side
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_ball |=> !out_valid)
		else $error("beat after the last ball");

	// a stalled beat keeps its index
	a_hold_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_index))
		else $error("stalled beat changed");

endmodule

bind bouncing_balls_box_step_unit bbs_checker u_bbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_index (out_index),
	.last_ball (last_ball)
);
